// ===== src/semaphore_table_with_wait_queues_assert.svh =====
// Assertion macros for the semaphore table.
// Both take a label, a property expression and a message, and are clocked on clk_i.
// STWQ_ASSERT is held off while rst_ni is low.
// STWQ_ASSERT_ALWAYS is also checked during reset.
`ifndef SEMAPHORE_TABLE_WITH_WAIT_QUEUES_ASSERT_SVH
`define SEMAPHORE_TABLE_WITH_WAIT_QUEUES_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define STWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define STWQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define STWQ_ASSERT(lbl, prop, msg)
`define STWQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/stwq_pkg.sv =====
package stwq_pkg;

  localparam int unsigned NumSem     = 16;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PidBits    = 8;

  localparam int unsigned SemW       = $clog2(NumSem);
  localparam int unsigned QIdxW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);
  localparam int unsigned StoreDepth = NumSem * QueueDepth;
  localparam int unsigned StoreAddrW = $clog2(StoreDepth);

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_WAIT   = 2'd2,
    MODE_SIGNAL = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_QUEUE_FULL = 2'd2,
    ST_NOT_HELD   = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

  // flat address of a queue slot in the waiter store
  function automatic logic [StoreAddrW-1:0] store_addr(input logic [SemW-1:0]  sem,
                                                       input logic [QIdxW-1:0] slot);
    store_addr = StoreAddrW'(int'(sem) * QueueDepth + int'(slot));
  endfunction

endpackage

// ===== src/stwq_ram.sv =====
module stwq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/stwq_ctrl.sv =====
module stwq_ctrl import stwq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
            ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          // hold until the result register is free
          if (!sts_i.out_busy) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
      endcase
    end
  end

  assign in_ready_o   = ready_q;
  assign cmd_o.accept = in_valid_i & ready_q;
  assign cmd_o.commit = (state_q == S_EXEC) & ~sts_i.out_busy;

endmodule

// ===== src/stwq_dp.sv =====
module stwq_dp import stwq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_sts_t    sts_o,
  input  logic [1:0] mode_i,
  input  logic [3:0] sem_id_i,
  input  logic [7:0] caller_pid_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [1:0] status_o,
  output logic [3:0] granted_id_o,
  output logic       must_block_o,
  output logic       wake_valid_o,
  output logic [7:0] wake_pid_o
);

  // semaphore table
  logic [NumSem-1:0] in_use_q, in_use_d;
  logic [NumSem-1:0] locked_q, locked_d;
  logic [QIdxW-1:0]  head_q [NumSem];
  logic [QIdxW-1:0]  head_d [NumSem];
  logic [QCntW-1:0]  cnt_q  [NumSem];
  logic [QCntW-1:0]  cnt_d  [NumSem];

  // captured request
  mode_e               mode_q;
  logic                in_range_q;
  logic [SemW-1:0]     sem_q;
  logic [PidBits-1:0]  pid_q;

  // result register
  logic    out_valid_q;
  status_e status_q, status_d;
  logic [3:0] granted_q, granted_d;
  logic block_q, block_d;
  logic wvalid_q, wvalid_d;
  logic [7:0] wpid_q, wpid_d;

  // waiter store ports
  logic                  rd_in_range;
  logic [SemW-1:0]       rd_sem;
  logic [StoreAddrW-1:0] rd_addr;
  logic [PidBits-1:0]    rd_data;
  logic                  wr_en;
  logic [StoreAddrW-1:0] wr_addr;

  // queue arithmetic
  logic             cur_locked;
  logic [QIdxW-1:0] cur_head;
  logic [QCntW-1:0] cur_cnt;
  logic [QIdxW:0]   tail_sum;
  logic [QIdxW-1:0] tail;
  logic [QIdxW-1:0] head_next;
  logic             q_full;

  logic            any_free;
  logic [SemW-1:0] free_idx;

  // head slot is read while the item is taken, data lands for the commit cycle
  assign rd_in_range = (int'(sem_id_i) < NumSem);
  assign rd_sem      = rd_in_range ? SemW'(sem_id_i) : '0;
  assign rd_addr     = store_addr(rd_sem, head_q[rd_sem]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q     <= mode_e'(mode_i);
      in_range_q <= rd_in_range;
      sem_q      <= rd_sem;
      pid_q      <= PidBits'(caller_pid_i);
    end
  end

  assign cur_locked = locked_q[sem_q];
  assign cur_head   = head_q[sem_q];
  assign cur_cnt    = cnt_q[sem_q];
  assign q_full     = (cur_cnt >= QCntW'(QueueDepth));

  // ring wrap: head and count both below depth when not full
  assign tail_sum  = (QIdxW+1)'(cur_head) + (QIdxW+1)'(cur_cnt);
  assign tail      = (tail_sum >= (QIdxW+1)'(QueueDepth)) ?
                     QIdxW'(tail_sum - (QIdxW+1)'(QueueDepth)) : QIdxW'(tail_sum);
  assign head_next = (cur_head == QIdxW'(QueueDepth - 1)) ? '0 : cur_head + 1'b1;

  // lowest free semaphore
  assign any_free = ~&in_use_q;
  always_comb begin
    free_idx = '0;
    for (int i = NumSem - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx = SemW'(i);
      end
    end
  end

  always_comb begin
    in_use_d  = in_use_q;
    locked_d  = locked_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    status_d  = ST_OK;
    granted_d = '0;
    block_d   = 1'b0;
    wvalid_d  = 1'b0;
    wpid_d    = '0;
    wr_en     = 1'b0;
    wr_addr   = store_addr(sem_q, tail);
    unique case (mode_q)
      MODE_ALLOC: begin
        if (any_free) begin
          in_use_d[free_idx] = 1'b1;
          locked_d[free_idx] = 1'b0;
          head_d[free_idx]   = '0;
          cnt_d[free_idx]    = '0;
          granted_d          = 4'(free_idx);
        end else begin
          status_d = ST_NO_FREE;
        end
      end
      MODE_FREE: begin
        if (in_range_q && in_use_q[sem_q]) begin
          in_use_d[sem_q] = 1'b0;
          locked_d[sem_q] = 1'b0;
          head_d[sem_q]   = '0;
          cnt_d[sem_q]    = '0;
        end
      end
      MODE_WAIT: begin
        if (in_range_q) begin
          if (!cur_locked) begin
            locked_d[sem_q] = 1'b1;
          end else if (q_full) begin
            status_d = ST_QUEUE_FULL;
          end else begin
            wr_en        = 1'b1;
            cnt_d[sem_q] = cur_cnt + 1'b1;
            block_d      = 1'b1;
          end
        end
      end
      MODE_SIGNAL: begin
        if (in_range_q) begin
          if (!cur_locked) begin
            status_d = ST_NOT_HELD;
          end else if (cur_cnt == '0) begin
            locked_d[sem_q] = 1'b0;
          end else begin
            // lock passes straight to the oldest waiter
            wvalid_d      = 1'b1;
            wpid_d        = 8'(rd_data);
            head_d[sem_q] = head_next;
            cnt_d[sem_q]  = cur_cnt - 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      locked_q <= '0;
      for (int i = 0; i < NumSem; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (cmd_i.commit) begin
      in_use_q <= in_use_d;
      locked_q <= locked_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      block_q   <= block_d;
      wvalid_q  <= wvalid_d;
      wpid_q    <= wpid_d;
    end
  end

  stwq_ram #(
    .Width (PidBits),
    .Depth (StoreDepth)
  ) u_waiter_store (
    .clk_i   (clk_i),
    .we_i    (wr_en & cmd_i.commit),
    .waddr_i (wr_addr),
    .wdata_i (pid_q),
    .re_i    (cmd_i.accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign sts_o.out_busy = out_valid_q & ~out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign granted_id_o = granted_q;
  assign must_block_o = block_q;
  assign wake_valid_o = wvalid_q;
  assign wake_pid_o   = wpid_q;

endmodule

// ===== src/semaphore_table_with_wait_queues.sv =====
// Channel   Handshake                  Payload
// request   in_valid_i / in_ready_o    mode_i, sem_id_i, caller_pid_i
// result    out_valid_o / out_ready_i  status_o, granted_id_o, must_block_o,
//                                      wake_valid_o, wake_pid_o
//
// Each item has two steps: the accept cycle reads the head slot of the
// addressed wait queue from the waiter store RAM (registered read); the commit
// cycle updates the table and loads the result register.
// A new item is taken while a result waits; the commit cycle holds while the
// result register is still full, and in_ready_o stays low meanwhile.
// Reset clears the table; the waiter store needs no clearing.

`include "semaphore_table_with_wait_queues_assert.svh"

module semaphore_table_with_wait_queues import stwq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [3:0] sem_id_i,
  input  logic [7:0] caller_pid_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [3:0] granted_id_o,
  output logic       must_block_o,
  output logic       wake_valid_o,
  output logic [7:0] wake_pid_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  // sequencing: idle -> exec -> idle
  stwq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  // table, waiter store and result register
  stwq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .sts_o        (dp_sts),
    .mode_i       (mode_i),
    .sem_id_i     (sem_id_i),
    .caller_pid_i (caller_pid_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .granted_id_o (granted_id_o),
    .must_block_o (must_block_o),
    .wake_valid_o (wake_valid_o),
    .wake_pid_o   (wake_pid_o)
  );

  // only one item in flight
  `STWQ_ASSERT(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o, "second item taken")
  // a commit always leaves a result on offer
  `STWQ_ASSERT(a_commit_shows, ctrl_cmd.commit |=> out_valid_o, "committed result lost")
  // a result cannot both queue the caller and wake a waiter
  `STWQ_ASSERT(a_block_xor_wake, out_valid_o |-> !(must_block_o && wake_valid_o), "block and wake")
  // error results carry no side effects
  `STWQ_ASSERT(a_err_clean,
    (out_valid_o && status_o != ST_OK) |-> (!must_block_o && !wake_valid_o), "flags on error")
  // accept and commit never coincide
  `STWQ_ASSERT_ALWAYS(a_cmd_excl, !(ctrl_cmd.accept && ctrl_cmd.commit), "accept during commit")

endmodule
